// ===== design/edf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_pkg: shared types and constants of the deadline scheduler
// Cell command and candidate words passed along the row of task cells.
// ----------------------------------------------------------------------------
package edf_pkg;

  localparam int TIME_W = 16;
  localparam int DYN_W = TIME_W + 1;
  // slot index width that covers the largest supported slot count (64)
  localparam int SLOT_W = 6;
  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic tick;
    logic load;
    logic is_run;
    logic in_use;
    logic [TIME_W-1:0] budget;
    logic [TIME_W-1:0] deadline;
    logic [TIME_W-1:0] period;
  } cell_cmd_t;

  typedef struct packed {
    logic found;
    logic [SLOT_W-1:0] idx;
    logic signed [DYN_W-1:0] dyn;
    logic run_open;
  } cand_t;

endpackage

// ===== design/edf_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_if: handshake channels of the deadline scheduler
// Input word, result word and configuration write channels.
// ----------------------------------------------------------------------------
interface edf_in_if;
  logic valid;
  logic ready;
  logic operation;
  logic [2:0] task_slot;
  logic [15:0] compute_budget;
  logic [15:0] relative_deadline;
  logic [15:0] task_period;

  modport source (output valid, operation, task_slot, compute_budget, relative_deadline,
                  task_period, input ready);
  modport sink (input valid, operation, task_slot, compute_budget, relative_deadline,
                task_period, output ready);
endinterface

interface edf_out_if;
  logic valid;
  logic ready;
  logic [2:0] chosen_task;
  logic idle;
  logic switched;
  logic preempted;
  logic [31:0] switch_total;
  logic [31:0] preempt_total;

  modport source (output valid, chosen_task, idle, switched, preempted, switch_total,
                  preempt_total, input ready);
  modport sink (input valid, chosen_task, idle, switched, preempted, switch_total,
                preempt_total, output ready);
endinterface

interface edf_cfg_if;
  logic valid;
  logic ready;
  logic [3:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ===== design/edf_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_cell: one task slot of the scheduler row
// Holds the slot's timing state, loads it on a load command and updates it on a tick;
// it folds itself into the earliest-deadline candidate handed on to the next cell.
// ----------------------------------------------------------------------------
module edf_cell import edf_pkg::*; #(
  parameter int INDEX = 0
) (
  input  logic      clk,
  input  logic      rst,
  input  cell_cmd_t cmd,
  input  logic      go_in,
  input  cand_t     cand_in,
  output logic      go_out,
  output cand_t     cand_out
);

  logic [TIME_W-1:0] budget, deadline, period, elapsed, served;
  logic done;
  logic signed [DYN_W-1:0] dyn;

  logic [TIME_W-1:0] served_c, served_next, elapsed_z, elapsed_next;
  logic done_next;
  logic signed [DYN_W-1:0] dyn_next;
  logic take;
  cand_t cand_next;

  always_comb begin
    served_c = (cmd.is_run && served != TIME_MAX) ? served + 1'b1 : served;
    done_next = done;
    elapsed_z = elapsed;
    served_next = served_c;
    if (cmd.in_use) begin
      if (served_c >= budget) begin
        done_next = 1'b1;
      end
      if (period == elapsed) begin
        elapsed_z = '0;
        served_next = '0;
        done_next = 1'b0;
      end
    end
    dyn_next = $signed({1'b0, deadline}) - $signed({1'b0, elapsed_z});
    elapsed_next = (elapsed_z != TIME_MAX) ? elapsed_z + 1'b1 : elapsed_z;
  end

  always_comb begin
    take = cmd.in_use && !done && (!cand_in.found || dyn < cand_in.dyn);
    cand_next = cand_in;
    if (take) begin
      cand_next.found = 1'b1;
      cand_next.idx = SLOT_W'(INDEX);
      cand_next.dyn = dyn;
    end
    cand_next.run_open = cand_in.run_open | (cmd.is_run && served < budget);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      budget <= '0;
      deadline <= '0;
      period <= '0;
      elapsed <= '0;
      served <= '0;
      done <= 1'b0;
      dyn <= '0;
      go_out <= 1'b0;
      cand_out <= '0;
    end else begin
      go_out <= go_in;
      if (go_in) begin
        cand_out <= cand_next;
      end
      if (cmd.load) begin
        budget <= cmd.budget;
        deadline <= cmd.deadline;
        period <= cmd.period;
        elapsed <= '0;
        served <= '0;
        done <= 1'b0;
      end else if (cmd.tick) begin
        served <= served_next;
        if (cmd.in_use) begin
          done <= done_next;
          dyn <= dyn_next;
          elapsed <= elapsed_next;
        end
      end
    end
  end

endmodule

// ===== design/edf_task_scheduler_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_task_scheduler_core: periodic-task deadline scheduler
// A load word goes straight to the decision state, which registers its result.
// For a tick word all cells update at the accepting edge, the candidate walks the
// row one cell per cycle and is handed over to the decision state, which registers
// the decision. A new word is taken only once the result of the last is registered;
// a stall at the output holds the decision state and with it the input.
// Synchronous reset clears all slots, counters and task_count.
// ----------------------------------------------------------------------------
module edf_task_scheduler_core import edf_pkg::*; #(
  parameter int MAX_TASKS = 8
) (
  input  logic clk,
  input  logic rst,
  edf_cfg_if.sink    cfg,
  edf_in_if.sink     sched_in,
  edf_out_if.source  sched_out
);

  localparam int RUN_W = $clog2(MAX_TASKS + 1);
  localparam logic [RUN_W-1:0] IDLE_CODE = RUN_W'(MAX_TASKS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0] st;
  logic is_load;
  logic scan_start;
  logic [3:0] task_count;
  logic [RUN_W-1:0] running;
  logic [31:0] switch_cnt, preempt_cnt;

  logic out_valid;
  logic [2:0] out_chosen;
  logic out_idle, out_sw, out_pre;
  logic [31:0] out_sw_total, out_pre_total;

  logic in_fire, tick_fire, load_fire, can_emit, emit;
  cell_cmd_t cmd_bus [MAX_TASKS];
  cand_t cand_bus [MAX_TASKS+1];
  logic [MAX_TASKS:0] go_bus;

  cand_t last;
  logic [RUN_W-1:0] pick, running_next;
  logic sw_n, pre_n;
  logic [31:0] switch_cnt_next, preempt_cnt_next;

  assign cfg.ready = 1'b1;
  assign sched_in.ready = (st == ST_IDLE);
  assign in_fire = sched_in.valid && sched_in.ready;
  assign tick_fire = in_fire && (sched_in.operation == OP_TICK);
  assign load_fire = in_fire && (sched_in.operation == OP_LOAD);

  assign cand_bus[0] = '0;
  assign go_bus[0] = scan_start;

  for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
    always_comb begin
      cmd_bus[k].tick = tick_fire;
      cmd_bus[k].load = load_fire && (int'(sched_in.task_slot) == k);
      cmd_bus[k].is_run = (running == RUN_W'(k));
      cmd_bus[k].in_use = (int'(task_count) > k);
      cmd_bus[k].budget = sched_in.compute_budget;
      cmd_bus[k].deadline = sched_in.relative_deadline;
      cmd_bus[k].period = sched_in.task_period;
    end

    edf_cell #(.INDEX(k)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd_bus[k]),
      .go_in    (go_bus[k]),
      .cand_in  (cand_bus[k]),
      .go_out   (go_bus[k+1]),
      .cand_out (cand_bus[k+1])
    );
  end

  // decision from the candidate at the end of the row
  always_comb begin
    last = cand_bus[MAX_TASKS];
    pick = RUN_W'(last.idx);
    sw_n = !is_load && last.found && (pick != running);
    pre_n = sw_n && (running != IDLE_CODE) && last.run_open;
    if (is_load) begin
      running_next = running;
    end else if (last.found) begin
      running_next = pick;
    end else begin
      running_next = IDLE_CODE;
    end
    switch_cnt_next = sw_n ? switch_cnt + 32'd1 : switch_cnt;
    preempt_cnt_next = pre_n ? preempt_cnt + 32'd1 : preempt_cnt;
  end

  assign can_emit = !out_valid || sched_out.ready;
  assign emit = (st == ST_DONE) && can_emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      is_load <= 1'b0;
      scan_start <= 1'b0;
      task_count <= '0;
      running <= IDLE_CODE;
      switch_cnt <= '0;
      preempt_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      scan_start <= tick_fire;
      if (cfg.valid && cfg.ready) begin
        task_count <= cfg.data;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (sched_out.ready) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        ST_IDLE: begin
          if (in_fire) begin
            is_load <= load_fire;
            st <= load_fire ? ST_DONE : ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (go_bus[MAX_TASKS]) begin
            st <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (can_emit) begin
            running <= running_next;
            switch_cnt <= switch_cnt_next;
            preempt_cnt <= preempt_cnt_next;
            st <= ST_IDLE;
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_chosen <= (running_next == IDLE_CODE) ? 3'd0 : 3'(running_next);
      out_idle <= (running_next == IDLE_CODE);
      out_sw <= sw_n;
      out_pre <= pre_n;
      out_sw_total <= switch_cnt_next;
      out_pre_total <= preempt_cnt_next;
    end
  end

  assign sched_out.valid = out_valid;
  assign sched_out.chosen_task = out_chosen;
  assign sched_out.idle = out_idle;
  assign sched_out.switched = out_sw;
  assign sched_out.preempted = out_pre;
  assign sched_out.switch_total = out_sw_total;
  assign sched_out.preempt_total = out_pre_total;

  a_go_single: assert property (@(posedge clk) disable iff (rst) $onehot0(go_bus))
    else $error("more than one cell active in the scan");

  a_pre_needs_sw: assert property (@(posedge clk) disable iff (rst)
    sched_out.valid && sched_out.preempted |-> sched_out.switched && !sched_out.idle)
    else $error("preemption reported without a switch");

  a_sw_count: assert property (@(posedge clk) disable iff (rst)
    emit && sw_n |=> switch_cnt == $past(switch_cnt) + 32'd1)
    else $error("switch counter did not advance");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    st == ST_SCAN |-> !sched_in.ready)
    else $error("input taken during scan");

endmodule
